// ===== hdl/llc_pkg.sv =====
// Shared types, field widths, case and class codes and the fixed regression
// coefficients of the lift load classifier. No dependencies.

package llc_pkg;

	localparam int SAMPLE_W = 10;
	localparam int EST_W    = 17;
	localparam int CFG_W    = 17;
	localparam int ACC_W    = 30;  // holds every case sum, signed Q.16
	localparam int FRAC_DROP = 12; // Q.16 to Q.4

	localparam logic [EST_W-1:0] EST_MAX = {EST_W{1'b1}};

	typedef logic signed [ACC_W-1:0] acc_t;

	typedef enum logic [1:0] {
		REG_PALM_LEVEL   = 2'd0,
		REG_FINGER_LEVEL = 2'd1,
		REG_LIGHT_LIMIT  = 2'd2,
		REG_OVERLOAD_LIM = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		CASE_NONE         = 3'd0,
		CASE_EDGE         = 3'd1,
		CASE_PALM         = 3'd2,
		CASE_LEFT_HANDLE  = 3'd3,
		CASE_RIGHT_HANDLE = 3'd4,
		CASE_GENERAL      = 3'd5
	} lift_case_t;

	typedef enum logic [1:0] {
		LOAD_LIGHT    = 2'd0,
		LOAD_HEAVY    = 2'd1,
		LOAD_OVERLOAD = 2'd2
	} load_class_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] palm_active_level;
		logic [SAMPLE_W-1:0] finger_active_level;
		logic [EST_W-1:0]    light_limit;
		logic [EST_W-1:0]    overload_limit;
	} llc_cfg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] left_upper;
		logic [SAMPLE_W-1:0] left_lower;
		logic [SAMPLE_W-1:0] left_tip;
		logic [SAMPLE_W-1:0] right_upper;
		logic [SAMPLE_W-1:0] right_lower;
		logic [SAMPLE_W-1:0] right_tip;
	} llc_samples_t;

	typedef struct packed {
		load_class_t      load_class;
		logic [EST_W-1:0] weight_estimate;
		lift_case_t       lift_case;
	} llc_result_t;

	// Regression coefficients, Q.16
	localparam acc_t EDGE_LT  = 30'sd2971;
	localparam acc_t EDGE_RT  = 30'sd76827;
	localparam acc_t EDGE_OFS = -30'sd192703;

	localparam acc_t PALM_LL  = 30'sd7065;
	localparam acc_t PALM_LT  = -30'sd48153;
	localparam acc_t PALM_RL  = 30'sd8103;
	localparam acc_t PALM_RT  = 30'sd385005;
	localparam acc_t PALM_OFS = -30'sd3167886;

	localparam acc_t LH_LU  = -30'sd1867;
	localparam acc_t LH_LT  = 30'sd64264;
	localparam acc_t LH_OFS = -30'sd155157;

	localparam acc_t RH_RU  = 30'sd3745;
	localparam acc_t RH_RT  = 30'sd620;
	localparam acc_t RH_OFS = 30'sd128578;

	localparam acc_t GEN_LU  = 30'sd1425;
	localparam acc_t GEN_LL  = 30'sd631;
	localparam acc_t GEN_LT  = 30'sd26253;
	localparam acc_t GEN_RU  = 30'sd228;
	localparam acc_t GEN_RL  = 30'sd6474;
	localparam acc_t GEN_RT  = 30'sd33893;
	localparam acc_t GEN_OFS = -30'sd3787;

	localparam acc_t ROUND_HALF = 30'sd2048;

endpackage

// ===== hdl/llc_sample_if.sv =====
// Sample channel of the lift load classifier: valid/ready plus six samples.
// Depends on llc_pkg.

interface llc_sample_if import llc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] left_upper;
	logic [SAMPLE_W-1:0] left_lower;
	logic [SAMPLE_W-1:0] left_tip;
	logic [SAMPLE_W-1:0] right_upper;
	logic [SAMPLE_W-1:0] right_lower;
	logic [SAMPLE_W-1:0] right_tip;

	modport source (
		output valid, left_upper, left_lower, left_tip,
		output right_upper, right_lower, right_tip,
		input  ready
	);
	modport sink (
		input  valid, left_upper, left_lower, left_tip,
		input  right_upper, right_lower, right_tip,
		output ready
	);
endinterface

// ===== hdl/llc_result_if.sv =====
// Result channel of the lift load classifier: valid/ready plus class,
// estimate and lift case. Depends on llc_pkg.

interface llc_result_if import llc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       load_class;
	logic [EST_W-1:0] weight_estimate;
	logic [2:0]       lift_case;

	modport source (
		output valid, load_class, weight_estimate, lift_case,
		input  ready
	);
	modport sink (
		input  valid, load_class, weight_estimate, lift_case,
		output ready
	);
endinterface

// ===== hdl/lift_load_classifier.sv =====
// Top level of the lift load classifier: configuration registers, input and
// result pipeline registers. Depends on llc_pkg, llc_sample_if,
// llc_result_if and llc_estimator.
//
//   channel   direction  handshake          payload
//   samples   in         valid/ready        six 10-bit pressure samples
//   results   out        valid/ready        load_class, weight_estimate, lift_case
//   cfg       in         cfg_we (no ready)  cfg_index, cfg_wdata
//
// One sample set per cycle sustained while the result channel is ready; a set
// passes from the input register through the estimator to the result register.
// Reset restores the configuration defaults and empties both stages.
// A stalled result holds in the result register while the input register
// keeps taking a new set whenever it is empty or moving forward, so a
// stall costs no throughput until both stages are full.

module lift_load_classifier import llc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [CFG_W-1:0]   cfg_wdata,
	llc_sample_if.sink         samples,
	llc_result_if.source       results
);

	llc_cfg_t     cfg_q;
	llc_samples_t sample_s1;
	logic         valid_s1;
	llc_result_t  result_s2;
	logic         valid_s2;
	llc_result_t  est_result;
	logic         adv_s2;
	logic         in_take;

	// Configuration write port; software must write only while the block is idle (not enforced here).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.palm_active_level   <= SAMPLE_W'(256);
			cfg_q.finger_active_level <= SAMPLE_W'(1023);
			cfg_q.light_limit         <= EST_W'(80);
			cfg_q.overload_limit      <= EST_W'(320);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_PALM_LEVEL:   cfg_q.palm_active_level   <= cfg_wdata[SAMPLE_W-1:0];
				REG_FINGER_LEVEL: cfg_q.finger_active_level <= cfg_wdata[SAMPLE_W-1:0];
				REG_LIGHT_LIMIT:  cfg_q.light_limit         <= cfg_wdata[EST_W-1:0];
				REG_OVERLOAD_LIM: cfg_q.overload_limit      <= cfg_wdata[EST_W-1:0];
				default: ;
			endcase
		end
	end

	// Result stage moves when empty or when downstream takes the result;
	// input stage accepts when empty or when it moves into the result stage.
	assign adv_s2        = !valid_s2 || results.ready;
	assign samples.ready = !valid_s1 || adv_s2;
	assign in_take       = samples.valid && samples.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Capture the incoming transaction.
	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_s1.left_upper  <= samples.left_upper;
			sample_s1.left_lower  <= samples.left_lower;
			sample_s1.left_tip    <= samples.left_tip;
			sample_s1.right_upper <= samples.right_upper;
			sample_s1.right_lower <= samples.right_lower;
			sample_s1.right_tip   <= samples.right_tip;
		end
	end

	llc_estimator u_estimator (
		.samples (sample_s1),
		.cfg     (cfg_q),
		.result  (est_result)
	);

	// Advance the estimate into the result register; hold it while stalled.
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			result_s2 <= est_result;
		end
	end

	assign results.valid           = valid_s2;
	assign results.load_class      = result_s2.load_class;
	assign results.weight_estimate = result_s2.weight_estimate;
	assign results.lift_case       = result_s2.lift_case;

`ifndef ASSERT_OFF
	// No lift means no weight.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.lift_case == CASE_NONE |-> result_s2.weight_estimate == '0)
		else $error("lift case none with nonzero estimate");

	// Class must agree with the configured limits.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.weight_estimate < cfg_q.light_limit
		|-> result_s2.load_class == LOAD_LIGHT)
		else $error("estimate below light limit not classed light");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.weight_estimate >= cfg_q.light_limit
		&& result_s2.weight_estimate >= cfg_q.overload_limit
		|-> result_s2.load_class == LOAD_OVERLOAD)
		else $error("estimate at both limits not classed overload");

	// An accepted transaction always occupies the input stage next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> valid_s1)
		else $error("accepted transaction lost from input stage");
`endif

endmodule

// ===== hdl/llc_estimator.sv =====
// Combinational datapath: sensor activity, lift case, per-case regression,
// clamp and saturation, load classification. Depends on llc_pkg.

module llc_estimator import llc_pkg::*; (
	input  llc_samples_t samples,
	input  llc_cfg_t     cfg,
	output llc_result_t  result
);

	acc_t lu, ll, lt, ru, rl, rt;
	logic a_lu, a_ll, a_lt, a_ru, a_rl, a_rt;
	logic left, right, up, low, fin;
	acc_t sum_edge, sum_palm, sum_lh, sum_rh, sum_gen;
	acc_t acc, rounded;
	logic [ACC_W-FRAC_DROP-1:0] shifted;
	logic [EST_W-1:0] est;
	lift_case_t kind;

	assign lu = ACC_W'(samples.left_upper);
	assign ll = ACC_W'(samples.left_lower);
	assign lt = ACC_W'(samples.left_tip);
	assign ru = ACC_W'(samples.right_upper);
	assign rl = ACC_W'(samples.right_lower);
	assign rt = ACC_W'(samples.right_tip);

	assign a_lu = samples.left_upper  >= cfg.palm_active_level;
	assign a_ll = samples.left_lower  >= cfg.palm_active_level;
	assign a_lt = samples.left_tip    >= cfg.finger_active_level;
	assign a_ru = samples.right_upper >= cfg.palm_active_level;
	assign a_rl = samples.right_lower >= cfg.palm_active_level;
	assign a_rt = samples.right_tip   >= cfg.finger_active_level;

	assign left  = a_lu | a_ll | a_lt;
	assign right = a_ru | a_rl | a_rt;
	assign up    = a_lu | a_ru;
	assign low   = a_ll | a_rl;
	assign fin   = a_lt | a_rt;

	// constant products only: shift-add trees
	assign sum_edge = lt * EDGE_LT + rt * EDGE_RT + EDGE_OFS;
	assign sum_palm = ll * PALM_LL + lt * PALM_LT + rl * PALM_RL + rt * PALM_RT + PALM_OFS;
	assign sum_lh   = lu * LH_LU + lt * LH_LT + LH_OFS;
	assign sum_rh   = ru * RH_RU + rt * RH_RT + RH_OFS;
	assign sum_gen  = lu * GEN_LU + ll * GEN_LL + lt * GEN_LT
	                + ru * GEN_RU + rl * GEN_RL + rt * GEN_RT + GEN_OFS;

	// first match wins
	always_comb begin
		if (left && right && !up && !low && fin) begin
			kind = CASE_EDGE;
			acc  = sum_edge;
		end else if (left && right && !up && low && fin) begin
			kind = CASE_PALM;
			acc  = sum_palm;
		end else if (left && !right && a_lu && !a_ll && a_lt) begin
			kind = CASE_LEFT_HANDLE;
			acc  = sum_lh;
		end else if (!left && right && a_ru && !a_rl && a_rt) begin
			kind = CASE_RIGHT_HANDLE;
			acc  = sum_rh;
		end else if (!left && !right) begin
			kind = CASE_NONE;
			acc  = '0;
		end else begin
			kind = CASE_GENERAL;
			acc  = sum_gen;
		end
	end

	// Q.16 to UQ13.4: clamp negatives, round half up, saturate
	assign rounded = acc + ROUND_HALF;
	assign shifted = rounded[ACC_W-1:FRAC_DROP];

	always_comb begin
		if (acc < 0) begin
			est = '0;
		end else if (shifted > (ACC_W-FRAC_DROP)'(EST_MAX)) begin
			est = EST_MAX;
		end else begin
			est = shifted[EST_W-1:0];
		end
	end

	always_comb begin
		result.lift_case       = kind;
		result.weight_estimate = est;
		if (est < cfg.light_limit) begin
			result.load_class = LOAD_LIGHT;
		end else if (est < cfg.overload_limit) begin
			result.load_class = LOAD_HEAVY;
		end else begin
			result.load_class = LOAD_OVERLOAD;
		end
	end

endmodule
